### rtl/ring_deque_palindrome_core_assert.svh
// Assertion macros shared by the deque modules.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef RING_DEQUE_PALINDROME_CORE_ASSERT_SVH
`define RING_DEQUE_PALINDROME_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define RDP_ASSERT_ALWAYS(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("deque assertion failed");

`define RDP_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("deque assertion failed");

`define RDP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`else

`define RDP_ASSERT_ALWAYS(lbl, ck, rn, prop)
`define RDP_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define RDP_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### rtl/rdp_pkg.sv
package rdp_pkg;

    // Operation requested by one input beat.
    typedef enum logic [1:0] {
        KIND_PUSH_BACK = 2'd0,
        KIND_POP_FRONT = 2'd1,
        KIND_POP_BACK  = 2'd2,
        KIND_CHECK     = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH,
        OP_PUSH_DROP,
        OP_POP_EMPTY,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_POP_CAPTURE,
        OP_CHK_START,
        OP_CHK_READ,
        OP_CHK_FAIL
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_CHK_RD,
        S_CHK_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic pairs_zero;
        logic mismatch;
        logic out_free;
    } sts_t;

endpackage

### rtl/rdp_ctrl.sv
`include "ring_deque_palindrome_core_assert.svh"

module rdp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    kind,
    output logic          in_stall,
    input  rdp_pkg::sts_t sts,
    output rdp_pkg::cmd_t cmd
);

    rdp_pkg::state_t state_reg;
    rdp_pkg::state_t state_next;
    rdp_pkg::kind_t  kind_in;

    assign kind_in = rdp_pkg::kind_t'(kind);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rdp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind_in)
                        rdp_pkg::KIND_PUSH_BACK:
                        begin
                            state_next = rdp_pkg::S_DONE;
                        end
                        rdp_pkg::KIND_POP_FRONT,
                        rdp_pkg::KIND_POP_BACK:
                        begin
                            state_next = sts.empty ? rdp_pkg::S_DONE : rdp_pkg::S_POP_WAIT;
                        end
                        rdp_pkg::KIND_CHECK:
                        begin
                            state_next = rdp_pkg::S_CHK_RD;
                        end
                    endcase
                end
            end
            rdp_pkg::S_POP_WAIT:
            begin
                state_next = rdp_pkg::S_DONE;
            end
            rdp_pkg::S_CHK_RD:
            begin
                state_next = sts.pairs_zero ? rdp_pkg::S_DONE : rdp_pkg::S_CHK_CMP;
            end
            rdp_pkg::S_CHK_CMP:
            begin
                state_next = sts.mismatch ? rdp_pkg::S_DONE : rdp_pkg::S_CHK_RD;
            end
            rdp_pkg::S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = rdp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rdp_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd.op       = rdp_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            rdp_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (kind_in)
                        rdp_pkg::KIND_PUSH_BACK:
                        begin
                            cmd.op = sts.full ? rdp_pkg::OP_PUSH_DROP : rdp_pkg::OP_PUSH;
                        end
                        rdp_pkg::KIND_POP_FRONT:
                        begin
                            cmd.op = sts.empty ? rdp_pkg::OP_POP_EMPTY : rdp_pkg::OP_POP_FRONT;
                        end
                        rdp_pkg::KIND_POP_BACK:
                        begin
                            cmd.op = sts.empty ? rdp_pkg::OP_POP_EMPTY : rdp_pkg::OP_POP_BACK;
                        end
                        rdp_pkg::KIND_CHECK:
                        begin
                            cmd.op = rdp_pkg::OP_CHK_START;
                        end
                    endcase
                end
            end
            rdp_pkg::S_POP_WAIT:
            begin
                cmd.op = rdp_pkg::OP_POP_CAPTURE;
            end
            rdp_pkg::S_CHK_RD:
            begin
                if (!sts.pairs_zero)
                begin
                    cmd.op = rdp_pkg::OP_CHK_READ;
                end
            end
            rdp_pkg::S_CHK_CMP:
            begin
                if (sts.mismatch)
                begin
                    cmd.op = rdp_pkg::OP_CHK_FAIL;
                end
            end
            rdp_pkg::S_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd.op = rdp_pkg::OP_NONE;
            end
        endcase
    end

    `RDP_ASSERT_IMPLY(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)
    `RDP_ASSERT_NEXT(a_pop_then_capture, clk, rst_n, (cmd.op == rdp_pkg::OP_POP_FRONT) || (cmd.op == rdp_pkg::OP_POP_BACK), cmd.op == rdp_pkg::OP_POP_CAPTURE)
    `RDP_ASSERT_NEXT(a_read_then_compare, clk, rst_n, cmd.op == rdp_pkg::OP_CHK_READ, state_reg == rdp_pkg::S_CHK_CMP)

endmodule

### rtl/rdp_datapath.sv
`include "ring_deque_palindrome_core_assert.svh"

module rdp_datapath #(
    parameter int DEPTH = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data,
    input  rdp_pkg::cmd_t cmd,
    output rdp_pkg::sts_t sts,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    value,
    output logic [1:0]    status,
    output logic          is_palindrome
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PAIR_W = CNT_W - 1;

    function automatic logic [IDX_W-1:0] wrap_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

    logic [7:0] store_mem [DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  back_reg, back_next;
    logic [PAIR_W-1:0] pairs_reg, pairs_next;

    logic [7:0]       res_value_reg, res_value_next;
    rdp_pkg::status_t res_status_reg, res_status_next;
    logic             res_pal_reg, res_pal_next;

    logic [7:0]       rd_a_reg, rd_b_reg;
    logic [7:0]       value_reg;
    rdp_pkg::status_t status_reg;
    logic             pal_reg;
    logic             out_valid_reg;

    logic [IDX_W-1:0] tail_dec;
    logic [IDX_W-1:0] addr_a, addr_b;
    logic             rd_en, wr_en;

    assign tail_dec = wrap_down(tail_reg);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        occ_next        = occ_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pairs_next      = pairs_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        res_pal_next    = res_pal_reg;
        addr_a          = front_reg;
        addr_b          = back_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        unique case (cmd.op)
            rdp_pkg::OP_PUSH:
            begin
                wr_en           = 1'b1;
                tail_next       = wrap_up(tail_reg);
                occ_next        = occ_reg + CNT_W'(1);
                res_value_next  = '0;
                res_status_next = rdp_pkg::STATUS_OK;
                res_pal_next    = 1'b0;
            end
            rdp_pkg::OP_PUSH_DROP:
            begin
                res_value_next  = '0;
                res_status_next = rdp_pkg::STATUS_FULL;
                res_pal_next    = 1'b0;
            end
            rdp_pkg::OP_POP_EMPTY:
            begin
                res_value_next  = '0;
                res_status_next = rdp_pkg::STATUS_EMPTY;
                res_pal_next    = 1'b0;
            end
            rdp_pkg::OP_POP_FRONT:
            begin
                rd_en           = 1'b1;
                addr_a          = head_reg;
                head_next       = wrap_up(head_reg);
                occ_next        = occ_reg - CNT_W'(1);
                res_status_next = rdp_pkg::STATUS_OK;
                res_pal_next    = 1'b0;
            end
            rdp_pkg::OP_POP_BACK:
            begin
                rd_en           = 1'b1;
                addr_a          = tail_dec;
                tail_next       = tail_dec;
                occ_next        = occ_reg - CNT_W'(1);
                res_status_next = rdp_pkg::STATUS_OK;
                res_pal_next    = 1'b0;
            end
            rdp_pkg::OP_POP_CAPTURE:
            begin
                res_value_next = rd_a_reg;
            end
            rdp_pkg::OP_CHK_START:
            begin
                // The walk uses its own pointers, so the deque is cleared at once.
                front_next      = head_reg;
                back_next       = tail_dec;
                pairs_next      = occ_reg[CNT_W-1:1];
                head_next       = '0;
                tail_next       = '0;
                occ_next        = '0;
                res_value_next  = '0;
                res_status_next = rdp_pkg::STATUS_OK;
                res_pal_next    = 1'b1;
            end
            rdp_pkg::OP_CHK_READ:
            begin
                rd_en      = 1'b1;
                front_next = wrap_up(front_reg);
                back_next  = wrap_down(back_reg);
                pairs_next = pairs_reg - PAIR_W'(1);
            end
            rdp_pkg::OP_CHK_FAIL:
            begin
                res_pal_next = 1'b0;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[tail_reg] <= data;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_mem[addr_a];
            rd_b_reg <= store_mem[addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        pairs_reg      <= pairs_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        res_pal_reg    <= res_pal_next;
        if (cmd.out_load)
        begin
            value_reg  <= res_value_reg;
            status_reg <= res_status_reg;
            pal_reg    <= res_pal_reg;
        end
    end

    assign sts.empty      = (occ_reg == '0);
    assign sts.full       = (occ_reg == CNT_W'(DEPTH));
    assign sts.pairs_zero = (pairs_reg == '0);
    assign sts.mismatch   = (rd_a_reg != rd_b_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign value         = value_reg;
    assign status        = status_reg;
    assign is_palindrome = pal_reg;

    `RDP_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_reg <= CNT_W'(DEPTH))
    `RDP_ASSERT_IMPLY(a_push_not_full, clk, rst_n, cmd.op == rdp_pkg::OP_PUSH, !sts.full)
    `RDP_ASSERT_NEXT(a_check_clears, clk, rst_n, cmd.op == rdp_pkg::OP_CHK_START, (occ_reg == '0) && (head_reg == '0) && (tail_reg == '0))

endmodule

### rtl/ring_deque_palindrome_core.sv
// Byte deque in a circular store of DEPTH entries with push_back, pop_front,
// pop_back and a palindrome check that also empties the deque. Every input beat
// yields exactly one result beat. A push, or a pop of an empty deque, goes from
// the idle state that accepts it straight to the done state. A pop with data
// passes through a wait state between the two, because the byte store has a
// registered read. The result enters the output register from the done state.
// A check of a deque with k = floor(occupancy/2) byte pairs walks the pairs in
// turn: it reads a pair from the two read ports of the store, then compares the
// two bytes. It ends once all k pairs match, or early at the first pair that
// differs. A new input beat is taken in the cycle after the previous result has
// reached the output register, even if that result still waits there. A result
// enters the output register only when that register is empty or its beat
// leaves at the same edge, so a stalled output holds the item in the done state.
// A push into a full deque drops the byte with the full status; a pop of an
// empty deque returns zero with the empty status.

module ring_deque_palindrome_core #(
    parameter int DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] value,
    output logic [1:0] status,
    output logic       is_palindrome
);

    // The controller and datapath exchange only these two bundles.
    rdp_pkg::cmd_t cmd;
    rdp_pkg::sts_t sts;

    // The sequencer decides the operation of each cycle from the beat's kind
    // and the datapath's status flags.
    rdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the store, the front and rear indices, the occupancy,
    // the check walk pointers and the output register.
    rdp_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data          (data),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .value         (value),
        .status        (status),
        .is_palindrome (is_palindrome)
    );

endmodule
